// ----- sv/pwd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwd_pkg
// Shared types and codes for the wire-format decoder: queued input word,
// result word, result kinds, error codes and wire types.
// ----------------------------------------------------------------------------
package pwd_pkg;

  localparam int LENGTH_BITS_DEF  = 32;
  localparam int VARINT_MAX_BYTES = 10;

  // Result kinds
  localparam logic [1:0] KIND_SCALAR  = 2'd0;
  localparam logic [1:0] KIND_LENGTH  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_MARKER  = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
  localparam logic [2:0] ERR_WIRE      = 3'd3;
  localparam logic [2:0] ERR_LENGTH    = 3'd4;

  // Wire types
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LENDEL  = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  // Input word after classification
  typedef struct packed {
    logic [7:0] data;
    logic       cont;
    logic       last;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] field_number;
    logic [2:0]  wire_kind;
    logic [63:0] value;
    logic        payload_last;
    logic [2:0]  error;
    logic        end_of_message;
  } result_t;

endpackage

// ----- sv/pwd_front.sv -----
// ----------------------------------------------------------------------------
// pwd_front
// Input side: classifies each byte and holds it in a two-word queue that
// feeds the decode back end.
// ----------------------------------------------------------------------------
module pwd_front
  import pwd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       message_end,
  output logic       q_valid,
  output in_word_t   q_word,
  input  logic       q_pop
);

  in_word_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_word  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // Store classified word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= '{data: data_byte, cont: data_byte[7], last: message_end};
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/pwd_back.sv -----
// ----------------------------------------------------------------------------
// pwd_back
// Decode back end: runs the tag/value state machine one word per cycle into
// an output register; a word that yields a result waits while it is held.
// ----------------------------------------------------------------------------
module pwd_back
  import pwd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  in_word_t q_word,
  output logic     q_pop,
  output logic     out_valid,
  output result_t  out_res,
  input  logic     pop
);

  typedef enum logic [2:0] {
    PH_TAG, PH_VARINT, PH_FIXED, PH_LENGTH, PH_PAYLOAD
  } phase_t;

  phase_t                 phase, phase_next;
  logic [63:0]            acc, acc_next;
  logic [3:0]             idx, idx_next;
  logic [31:0]            field, field_next;
  logic [2:0]             wire_type, wire_type_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic                   draining, draining_next;

  logic                   emit;
  result_t                res;
  logic                   advance;
  logic [5:0]             sh7;
  logic [63:0]            v_acc;
  logic [63:0]            f_acc;
  logic [3:0]             idx_inc;
  logic                   v_done;
  logic                   v_over;
  logic [3:0]             need;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   eom;

  function automatic result_t marker(input logic [2:0] err, input logic last);
    result_t r;
    r                = '0;
    r.kind           = KIND_MARKER;
    r.error          = err;
    r.end_of_message = last;
    return r;
  endfunction

  function automatic result_t normal(input logic [1:0] kind, input logic [31:0] fld,
                                     input logic [2:0] wt, input logic [63:0] val,
                                     input logic plast, input logic last);
    result_t r;
    r.kind           = kind;
    r.field_number   = fld;
    r.wire_kind      = wt;
    r.value          = val;
    r.payload_last   = plast;
    r.error          = ERR_NONE;
    r.end_of_message = last;
    return r;
  endfunction

  // Shared datapath terms
  assign eom     = q_word.last;
  assign sh7     = 6'({idx, 3'b000} - {3'b000, idx});
  assign v_acc   = acc | ({57'd0, q_word.data[6:0]} << sh7);
  assign f_acc   = acc | ({56'd0, q_word.data} << {idx[2:0], 3'b000});
  assign idx_inc = idx + 4'd1;
  assign v_done  = !q_word.cont;
  assign v_over  = q_word.cont && (idx_inc >= 4'(VARINT_MAX_BYTES));
  assign need    = (wire_type == WIRE_FIXED64) ? 4'd8 : 4'd4;
  assign rem_dec = (remaining != '0) ? remaining - LENGTH_BITS'(1) : remaining;

  // Decode one word
  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    idx_next       = idx;
    field_next     = field;
    wire_type_next = wire_type;
    remaining_next = remaining;
    draining_next  = draining;
    emit           = 1'b0;
    res            = '0;

    if (draining) begin
      if (eom) begin
        emit = 1'b1;
        res  = marker(ERR_NONE, 1'b1);
      end
    end else begin
      unique case (phase)
        PH_TAG: begin
          acc_next = v_acc;
          idx_next = idx_inc;
          if (v_done) begin
            wire_type_next = v_acc[2:0];
            field_next     = v_acc[34:3];
            acc_next       = '0;
            idx_next       = '0;
            case (v_acc[2:0]) inside
              WIRE_VARINT:                phase_next = PH_VARINT;
              WIRE_FIXED64, WIRE_FIXED32: phase_next = PH_FIXED;
              WIRE_LENDEL:                phase_next = PH_LENGTH;
              default: begin
                emit          = 1'b1;
                res           = marker(ERR_WIRE, eom);
                draining_next = 1'b1;
              end
            endcase
            if (eom && !emit) begin
              emit = 1'b1;
              res  = marker(ERR_UNDERFLOW, 1'b1);
            end
          end else if (eom) begin
            emit = 1'b1;
            res  = marker(ERR_NONE, 1'b1);
          end else if (v_over) begin
            emit          = 1'b1;
            res           = marker(ERR_OVERFLOW, 1'b0);
            draining_next = 1'b1;
          end
        end

        PH_VARINT: begin
          acc_next = v_acc;
          idx_next = idx_inc;
          if (v_done) begin
            phase_next = PH_TAG;
            acc_next   = '0;
            idx_next   = '0;
            emit       = 1'b1;
            res        = normal(KIND_SCALAR, field, wire_type, v_acc, 1'b0, eom);
          end else if (v_over) begin
            emit          = 1'b1;
            res           = marker(ERR_OVERFLOW, eom);
            draining_next = 1'b1;
          end else if (eom) begin
            emit = 1'b1;
            res  = marker(ERR_UNDERFLOW, 1'b1);
          end
        end

        PH_FIXED: begin
          acc_next = f_acc;
          idx_next = idx_inc;
          if (idx_inc >= need) begin
            phase_next = PH_TAG;
            acc_next   = '0;
            idx_next   = '0;
            emit       = 1'b1;
            res        = normal(KIND_SCALAR, field, wire_type, f_acc, 1'b0, eom);
          end else if (eom) begin
            emit = 1'b1;
            res  = marker(ERR_UNDERFLOW, 1'b1);
          end
        end

        PH_LENGTH: begin
          acc_next = v_acc;
          idx_next = idx_inc;
          if (v_done) begin
            acc_next = '0;
            idx_next = '0;
            emit     = 1'b1;
            if ((v_acc >> LENGTH_BITS) != 64'd0) begin
              res           = marker(ERR_LENGTH, eom);
              draining_next = 1'b1;
            end else if (v_acc == 64'd0) begin
              phase_next = PH_TAG;
              res        = normal(KIND_LENGTH, field, wire_type, 64'd0, 1'b0, eom);
            end else if (eom) begin
              res = marker(ERR_UNDERFLOW, 1'b1);
            end else begin
              phase_next     = PH_PAYLOAD;
              remaining_next = v_acc[LENGTH_BITS-1:0];
              res            = normal(KIND_LENGTH, field, wire_type, v_acc, 1'b0, 1'b0);
            end
          end else if (v_over) begin
            emit          = 1'b1;
            res           = marker(ERR_OVERFLOW, eom);
            draining_next = 1'b1;
          end else if (eom) begin
            emit = 1'b1;
            res  = marker(ERR_UNDERFLOW, 1'b1);
          end
        end

        PH_PAYLOAD: begin
          remaining_next = rem_dec;
          emit           = 1'b1;
          if (rem_dec == '0) begin
            phase_next = PH_TAG;
            res = normal(KIND_PAYLOAD, field, wire_type, {56'd0, q_word.data}, 1'b1, eom);
          end else if (eom) begin
            res = marker(ERR_UNDERFLOW, 1'b1);
          end else begin
            res = normal(KIND_PAYLOAD, field, wire_type, {56'd0, q_word.data}, 1'b0, 1'b0);
          end
        end

        default: begin
          phase_next = PH_TAG;
        end
      endcase
    end

    // Drop all context at message end
    if (eom) begin
      phase_next     = PH_TAG;
      acc_next       = '0;
      idx_next       = '0;
      field_next     = '0;
      wire_type_next = '0;
      remaining_next = '0;
      draining_next  = 1'b0;
    end
  end

  // Advance when no result is emitted or the result slot is free or being drained
  assign advance = q_valid && (!emit || !out_valid || pop);
  assign q_pop   = advance;

  // Hold state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TAG;
      acc       <= '0;
      idx       <= '0;
      field     <= '0;
      wire_type <= '0;
      remaining <= '0;
      draining  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase     <= phase_next;
        acc       <= acc_next;
        idx       <= idx_next;
        field     <= field_next;
        wire_type <= wire_type_next;
        remaining <= remaining_next;
        draining  <= draining_next;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
        out_res   <= res;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/protobuf_wire_decoder_top.sv -----
// ----------------------------------------------------------------------------
// protobuf_wire_decoder_top
// Streaming decoder for the protocol buffers wire format.
// ----------------------------------------------------------------------------
// Bytes of a serialized message enter through a queue-style push port, the
// last byte flagged by message_end. The decoder sustains one byte per cycle:
// the back-end state machine retires one queued byte per clock, and a byte
// that yields a result waits only if the result register is still held.
// An accepted byte is first written into the two-word input queue, and the
// back end then decodes it from the queue into the result register that
// drives the output ports. Each decoded value, length header and payload
// byte comes out as one word; the final byte of every message always yields
// exactly one word with end_of_message set. After an error, bytes are
// dropped until the message ends. Lengths of 2^LENGTH_BITS or more are
// flagged as errors.
// ----------------------------------------------------------------------------
module protobuf_wire_decoder_top
  import pwd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        message_end,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [31:0] field_number,
  output logic [2:0]  wire_kind,
  output logic [63:0] value,
  output logic        payload_last,
  output logic [2:0]  error,
  output logic        end_of_message
);

  logic     q_valid;
  in_word_t q_word;
  logic     q_pop;
  logic     out_valid;
  result_t  out_res;

  pwd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .message_end (message_end),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_pop       (q_pop)
  );

  pwd_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .pop       (pop)
  );

  assign empty          = !out_valid;
  assign kind           = out_res.kind;
  assign field_number   = out_res.field_number;
  assign wire_kind      = out_res.wire_kind;
  assign value          = out_res.value;
  assign payload_last   = out_res.payload_last;
  assign error          = out_res.error;
  assign end_of_message = out_res.end_of_message;

`ifndef SYNTHESIS
  a_marker_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == KIND_MARKER) |->
      (field_number == '0 && wire_kind == '0 && value == '0 && !payload_last))
    else $error("marker word carries nonzero fields");

  a_error_is_marker: assert property (@(posedge clk) disable iff (rst)
    (!empty && error != ERR_NONE) |-> (kind == KIND_MARKER))
    else $error("error flagged on a non-marker word");

  a_last_on_payload: assert property (@(posedge clk) disable iff (rst)
    (!empty && payload_last) |-> (kind == KIND_PAYLOAD))
    else $error("payload_last set outside a payload word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");
`endif

endmodule
